/* src/clsr_pkg.sv */
// Shared constants and types of the combined LCG shuffle generator.
package clsr_pkg;

  // Shuffle table size and derived index widths
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned SEED_STEPS  = TABLE_DEPTH + 8;
  localparam int unsigned STEP_W      = $clog2(SEED_STEPS);

  // Generator moduli and multipliers
  localparam logic [30:0] MOD1 = 31'd2147483563;
  localparam logic [30:0] MOD2 = 31'd2147483399;
  localparam logic [15:0] MUL1 = 16'd40014;
  localparam logic [15:0] MUL2 = 16'd40692;

  // 2^31 reduced by each modulus, for folding the high product bits
  localparam logic [7:0] FOLD1 = 8'(64'h8000_0000 - 64'(MOD1));
  localparam logic [7:0] FOLD2 = 8'(64'h8000_0000 - 64'(MOD2));

  localparam logic [30:0] SECOND_RESET = 31'd123456789;

  // Slot divisor and its fixed-point reciprocal
  localparam logic [30:0] SLOT_DIV =
    31'(64'd1 + (64'(MOD1) - 64'd2) / 64'(TABLE_DEPTH));
  localparam int unsigned RECIP_W = SLOT_W + 2;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(64'h1_0000_0000 / 64'(SLOT_DIV));

  // 2^32 - 2*MOD1, and the fraction ceiling
  localparam logic [7:0]  FRAC_FOLD = 8'(64'h1_0000_0000 - 64'd2 * 64'(MOD1));
  localparam logic [31:0] FRAC_MAX  = 32'd4294966780;

  // Request to the modular multiplier
  typedef struct packed {
    logic start;
    logic gen2;
  } mm_req_t;

endpackage

/* src/clsr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module clsr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/clsr_mulmod.sv */
// Modular multiplier with a registered product, shared by both generators.
module clsr_mulmod import clsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mm_req_t     req_i,
  input  logic [30:0] x_i,
  output logic        done_o,
  output logic [30:0] y_o
);

  logic [46:0] prod_d, prod_q;
  logic        gen2_q;
  logic        done_q;
  logic [15:0] hi;
  logic [31:0] sum;
  logic [7:0]  fold;
  logic [30:0] modv;

  // Multiply by the selected generator constant
  always_comb begin
    prod_d = 47'(x_i) * 47'(req_i.gen2 ? MUL2 : MUL1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod_d;
      gen2_q <= req_i.gen2;
    end
  end

  // Fold the bits above 2^31 back in, then one conditional subtract
  always_comb begin
    fold = gen2_q ? FOLD2 : FOLD1;
    modv = gen2_q ? MOD2 : MOD1;
    hi   = prod_q[46:31];
    sum  = 32'(prod_q[30:0]) + 32'(24'(hi) * 24'(fold));
    if (sum >= 32'(modv)) begin
      y_o = 31'(sum - 32'(modv));
    end else begin
      y_o = sum[30:0];
    end
  end

  assign done_o = done_q;

endmodule

/* src/clsr_post.sv */
// Two-stage pipeline from the last draw to its Q0.32 fraction and next slot.
module clsr_post import clsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [30:0]       draw_i,
  output logic [31:0]       frac_o,
  output logic [SLOT_W-1:0] slot_o
);

  localparam int unsigned PW = 31 + RECIP_W;
  localparam int unsigned RW = SLOT_W + 32;

  logic [30:0]         d_q;
  logic [38:0]         t_q;
  logic [PW-1:0]       rp_q;
  logic [31:0]         frac_d, frac_q;
  logic [SLOT_W-1:0]   slot_d, slot_q;
  logic [7:0]          th;
  logic [31:0]         rsum;
  logic [8:0]          quo;
  logic [32:0]         frac_w;
  logic [RECIP_W-2:0]  q0;
  logic [RW-1:0]       rem;
  logic [RECIP_W-1:0]  qf;

  // Stage one: constant products of the draw
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q  <= '0;
      t_q  <= '0;
      rp_q <= '0;
    end else begin
      d_q  <= draw_i;
      t_q  <= 39'(draw_i) * 39'(FRAC_FOLD);
      rp_q <= PW'(draw_i) * PW'(RECIP);
    end
  end

  // Stage two: fraction = 2d + floor(170d / MOD1), saturated
  always_comb begin
    th     = t_q[38:31];
    rsum   = 32'(t_q[30:0]) + 32'(16'(th) * 16'(FOLD1));
    quo    = 9'(th) + 9'(rsum >= 32'(MOD1));
    frac_w = {1'b0, d_q, 1'b0} + 33'(quo);
    if (frac_w > 33'(FRAC_MAX)) begin
      frac_d = FRAC_MAX;
    end else begin
      frac_d = frac_w[31:0];
    end
  end

  // Stage two: slot = draw / SLOT_DIV via reciprocal, one correction, saturate
  always_comb begin
    q0  = rp_q[PW-1:32];
    rem = RW'(d_q) - RW'(q0) * RW'(SLOT_DIV);
    qf  = RECIP_W'(q0) + RECIP_W'(rem >= RW'(SLOT_DIV));
    if (qf > RECIP_W'(TABLE_DEPTH - 1)) begin
      slot_d = SLOT_W'(TABLE_DEPTH - 1);
    end else begin
      slot_d = qf[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
      slot_q <= '0;
    end else begin
      frac_q <= frac_d;
      slot_q <= slot_d;
    end
  end

  assign frac_o = frac_q;
  assign slot_o = slot_q;

endmodule

/* src/combined_lcg_shuffle_rng.sv */
// Top level of the combined LCG generator with shuffle table.
//
// Each transfer in carries the caller's first-generator word; the block returns the advanced
// word, the shuffled draw and a saturated Q0.32 fraction. A positive word goes through the
// table read, two multiplies on the shared modular multiplier and the table write, then
// through the fraction and slot pipeline, and then loads the output register once that is
// free. A word of zero or less reseeds first: forty generator steps on the same multiplier,
// writing the shuffle RAM, then the settle states while the slot pipeline settles. A
// finished result waits in the output register while the next word is taken in. Table
// entries never written read as zero through per-entry valid bits cleared at reset.
module combined_lcg_shuffle_rng import clsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] gen_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [30:0]        next_gen_word_o,
  output logic [30:0]        draw_o,
  output logic [31:0]        fraction_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SEED_MUL  = 4'd1;
  localparam logic [3:0] S_SEED_WAIT = 4'd2;
  localparam logic [3:0] S_SETTLE1   = 4'd3;
  localparam logic [3:0] S_SETTLE2   = 4'd4;
  localparam logic [3:0] S_DRAW1     = 4'd5;
  localparam logic [3:0] S_DRAW2     = 4'd6;
  localparam logic [3:0] S_DRAW3     = 4'd7;
  localparam logic [3:0] S_DRAW4     = 4'd8;
  localparam logic [3:0] S_POST1     = 4'd9;
  localparam logic [3:0] S_POST2     = 4'd10;
  localparam logic [3:0] S_OUT       = 4'd11;

  logic [3:0]             state_d, state_q;
  logic [STEP_W-1:0]      j_d, j_q;
  logic [30:0]            x_d, x_q;
  logic [30:0]            second_d, second_q;
  logic [30:0]            last_d, last_q;
  logic                   hit_d, hit_q;
  logic [TABLE_DEPTH-1:0] valid_d, valid_q;
  logic                   out_valid_d, out_valid_q;
  logic                   out_load;
  logic [30:0]            out_next_q, out_draw_q;
  logic [31:0]            out_frac_q;

  logic                   in_xfer;
  logic                   reseed;
  logic [31:0]            neg_word;
  logic [30:0]            seed;

  mm_req_t                mm_req;
  logic [30:0]            mm_x;
  logic                   mm_done;
  logic [30:0]            mm_y;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [30:0]            ram_wdata;
  logic                   ram_re;
  logic [30:0]            ram_rdata;

  logic [31:0]            post_frac;
  logic [SLOT_W-1:0]      post_slot;

  logic [30:0]            tv;
  logic [32:0]            diff;
  logic [32:0]            mixed;

  // Shuffle table storage
  clsr_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (post_slot),
    .rdata_o (ram_rdata)
  );

  // Shared generator step
  clsr_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .x_i    (mm_x),
    .done_o (mm_done),
    .y_o    (mm_y)
  );

  // Fraction and slot from the last draw
  clsr_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .draw_i (last_q),
    .frac_o (post_frac),
    .slot_o (post_slot)
  );

  // Input decode: seed is the magnitude mod 2^31, zero becomes one
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign reseed     = gen_word_i[31] || (gen_word_i == 32'sd0);
  assign neg_word   = 32'd0 - 32'(gen_word_i);
  assign seed       = (neg_word[30:0] == 31'd0) ? 31'd1 : neg_word[30:0];

  // Combine the slot entry with the second generator, wrap below one
  always_comb begin
    tv    = hit_q ? ram_rdata : 31'd0;
    diff  = {2'b00, tv} - {2'b00, second_q};
    mixed = diff;
    if (diff[32] || (diff == 33'd0)) begin
      mixed = diff + 33'(MOD1 - 31'd1);
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    x_d       = x_q;
    second_d  = second_q;
    last_d    = last_q;
    hit_d     = hit_q;
    valid_d   = valid_q;
    out_load  = 1'b0;
    mm_req    = '0;
    mm_x      = x_q;
    ram_we    = 1'b0;
    ram_waddr = post_slot;
    ram_wdata = x_q;
    ram_re    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          j_d = STEP_W'(SEED_STEPS - 1);
          if (reseed) begin
            x_d      = seed;
            second_d = seed;
            state_d  = S_SEED_MUL;
          end else begin
            x_d     = gen_word_i[30:0];
            state_d = S_DRAW1;
          end
        end
      end
      S_SEED_MUL: begin
        mm_req.start = 1'b1;
        state_d      = S_SEED_WAIT;
      end
      S_SEED_WAIT: begin
        // Fill the table from the top slot down during the last steps
        x_d = mm_y;
        if (j_q < STEP_W'(TABLE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = j_q[SLOT_W-1:0];
          ram_wdata = mm_y;
          valid_d[j_q[SLOT_W-1:0]] = 1'b1;
        end
        if (j_q == '0) begin
          last_d  = mm_y;
          state_d = S_SETTLE1;
        end else begin
          j_d     = j_q - 1'b1;
          state_d = S_SEED_MUL;
        end
      end
      S_SETTLE1: begin
        state_d = S_SETTLE2;
      end
      S_SETTLE2: begin
        state_d = S_DRAW1;
      end
      S_DRAW1: begin
        // Advance the first generator, read the slot picked by the last draw
        mm_req.start = 1'b1;
        ram_re       = 1'b1;
        hit_d        = valid_q[post_slot];
        state_d      = S_DRAW2;
      end
      S_DRAW2: begin
        x_d          = mm_y;
        mm_req.start = 1'b1;
        mm_req.gen2  = 1'b1;
        mm_x         = second_q;
        state_d      = S_DRAW3;
      end
      S_DRAW3: begin
        second_d = mm_y;
        state_d  = S_DRAW4;
      end
      S_DRAW4: begin
        // Replace the slot with the new first-generator word
        last_d    = mixed[30:0];
        ram_we    = 1'b1;
        ram_waddr = post_slot;
        ram_wdata = x_q;
        valid_d[post_slot] = 1'b1;
        state_d   = S_POST1;
      end
      S_POST1: begin
        state_d = S_POST2;
      end
      S_POST2: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: drop on transfer, set on load
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      j_q         <= '0;
      second_q    <= SECOND_RESET;
      last_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      second_q    <= second_d;
      last_q      <= last_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    hit_q <= hit_d;
  end

  // Hold the result payload until the next load
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_next_q <= x_q;
      out_draw_q <= last_q;
      out_frac_q <= post_frac;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_gen_word_o = out_next_q;
  assign draw_o          = out_draw_q;
  assign fraction_o      = out_frac_q;

  // A delivered draw is never zero
  a_draw_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (draw_o != 31'd0))
    else $error("draw of zero delivered");

  // The fraction never passes its ceiling
  a_frac_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fraction_o <= FRAC_MAX))
    else $error("fraction above ceiling");

  // Multiplier results only land where the sequencer consumes them
  a_mm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (state_q == S_SEED_WAIT || state_q == S_DRAW2 || state_q == S_DRAW3))
    else $error("multiplier result not consumed");

  // The second generator is reduced before it is mixed
  a_second_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW4) |-> (second_q < MOD2))
    else $error("second generator not reduced at mix");

endmodule

/* dv/combined_lcg_shuffle_rng_tb.sv */
// Self-checking testbench for the combined LCG generator with shuffle table.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_tb;
  import clsr_pkg::*;

  // Generator constants in wide arithmetic
  localparam longint M1     = longint'(MOD1);
  localparam longint M2     = longint'(MOD2);
  localparam longint A1     = longint'(MUL1);
  localparam longint A2     = longint'(MUL2);
  localparam longint Q1     = 53668;
  localparam longint Q2     = 52774;
  localparam longint R1     = 12211;
  localparam longint R2     = 3791;
  localparam longint SLOT_D = 1 + (M1 - 2) / longint'(TABLE_DEPTH);
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     TARGET_ITEMS   = 950;

  typedef struct packed {
    logic [30:0] next_word;
    logic [30:0] draw;
    logic [31:0] fraction;
  } rng_result_t;

  // One directed row: input word, and the advanced word where it is known outright
  typedef struct packed {
    logic signed [31:0] word;
    logic               word_known;
    logic [30:0]        known_word;
  } word_row_t;

  localparam int NUM_ROWS = 20;
  word_row_t word_rows [0:NUM_ROWS-1] = '{
    // draws on the reset table, before any seeding
    {32'sd1,          1'b1, 31'd40014},
    {32'sd2,          1'b1, 31'd80028},
    {32'sd2147483562, 1'b1, 31'd2147443549},
    // above range: a word equal to the modulus advances to zero
    {32'sd2147483563, 1'b1, 31'd0},
    {32'sh7FFF_FFFF,  1'b1, 31'd3361176},
    {32'sd53668,      1'b1, 31'd2147471352},
    {32'sd53667,      1'b1, 31'd2147431338},
    // seeding: zero, minus one, most negative, most negative in range
    {32'sd0,          1'b0, 31'd0},
    {32'sd40014,      1'b0, 31'd0},
    {-32'sd1,         1'b0, 31'd0},
    {32'sh8000_0000,  1'b0, 31'd0},
    {32'sh8000_0001,  1'b0, 31'd0},
    {32'sd1,          1'b0, 31'd0},
    {-32'sd123456789, 1'b0, 31'd0},
    {32'sh5555_5555,  1'b0, 31'd0},
    {32'shAAAA_AAAA,  1'b0, 31'd0},
    {32'sh2AAA_AAAA,  1'b0, 31'd0},
    {-32'sd2,         1'b0, 31'd0},
    {32'sd2147483562, 1'b0, 31'd0},
    {32'sd12345,      1'b0, 31'd0}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic signed [31:0] gen_word    = '0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [30:0]        next_gen_word;
  logic [30:0]        draw;
  logic [31:0]        fraction;

  // Predictor state
  longint lcg2_state;
  longint prev_draw;
  longint shuffle_slots [TABLE_DEPTH];

  rng_result_t pending_draws [$];
  int          error_count = 0;
  int          items_sent  = 0;
  int          idle_cycles = 0;
  bit          quiet       = 1'b0;

  combined_lcg_shuffle_rng DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .gen_word_i     (gen_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .next_gen_word_o(next_gen_word),
    .draw_o         (draw),
    .fraction_o     (fraction)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Split-multiply step: a * x mod m without overflow
  function automatic longint lcg_step(longint x, longint a, longint q, longint r,
                                      longint m);
    longint k;
    longint y;
    k = x / q;
    y = a * (x - k * q) - k * r;
    if (y < 0) y += m;
    return y;
  endfunction

  function automatic void clear_generator();
    lcg2_state = 123456789;
    prev_draw  = 0;
    foreach (shuffle_slots[i]) shuffle_slots[i] = 0;
  endfunction

  // Advance the predictor by one transfer and return the expected result
  function automatic rng_result_t predict_draw(logic signed [31:0] w);
    longint      word;
    longint      seed;
    longint      slot;
    longint      mixed;
    longint      frac;
    rng_result_t res;
    word = longint'(w);
    if (word <= 0) begin
      seed = (-word) & 64'h7FFF_FFFF;
      if (seed == 0) seed = 1;
      word       = seed;
      lcg2_state = seed;
      for (int j = TABLE_DEPTH + 7; j >= 0; j--) begin
        word = lcg_step(word, A1, Q1, R1, M1);
        if (j < TABLE_DEPTH) shuffle_slots[j] = word;
      end
      prev_draw = shuffle_slots[0];
    end
    word       = lcg_step(word, A1, Q1, R1, M1);
    lcg2_state = lcg_step(lcg2_state, A2, Q2, R2, M2);
    slot = prev_draw / SLOT_D;
    if (slot > TABLE_DEPTH - 1) slot = TABLE_DEPTH - 1;
    mixed = shuffle_slots[slot] - lcg2_state;
    shuffle_slots[slot] = word;
    if (mixed < 1) mixed += M1 - 1;
    prev_draw = mixed & 64'h7FFF_FFFF;
    frac = (prev_draw << 32) / M1;
    if (frac > longint'(FRAC_MAX)) frac = longint'(FRAC_MAX);
    res.next_word = word[30:0];
    res.draw      = prev_draw[30:0];
    res.fraction  = frac[31:0];
    return res;
  endfunction

  // Idle length: mostly short, a few long, none while quiet
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (quiet) return 0;
    if (sel < 11) return 0;
    if (sel < 17) return $urandom_range(1, 3);
    if (sel < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one transfer in; record its expected result at acceptance
  task automatic send_word(input logic signed [31:0] w, input bit word_known,
                           input logic [30:0] known_word, output logic [30:0] next_word);
    int          gap;
    rng_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    gen_word <= w;
    do @(posedge clk_i); while (in_stall);
    res = predict_draw(w);
    if (word_known) res.next_word = known_word;
    pending_draws.push_back(res);
    next_word = res.next_word;
    items_sent++;
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_draws.size() != 0);
  endtask

  function automatic logic signed [31:0] noise_word();
    case ($urandom_range(0, 5))
      0: return 32'(M1 - 1);
      1: return 32'(M1 + longint'($urandom_range(0, 84)));
      2: return 32'sh8000_0000 + 32'($urandom_range(0, 3));
      3: return 32'($urandom_range(0, 70000));
      default: return $urandom();
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [30:0]        chained;
    logic signed [31:0] seed_word;
    int                 run_len;
    clear_generator();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (word_rows[i]) begin
      send_word(word_rows[i].word, word_rows[i].word_known, word_rows[i].known_word, chained);
    end
    drain_results();

    // random: mostly seeded chains fed back from the advanced word, some noise
    while (items_sent < TARGET_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) drain_results();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) == 0) seed_word = 32'sd0;
        else seed_word = -$signed({1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF))});
        send_word(seed_word, 1'b0, '0, chained);
        run_len = $urandom_range(5, 40);
        repeat (run_len) send_word($signed({1'b0, chained}), 1'b0, '0, chained);
      end else begin
        repeat ($urandom_range(1, 6)) send_word(noise_word(), 1'b0, '0, chained);
      end
    end

    // wait out the tail
    in_valid <= 1'b0;
    quiet = 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver stalls
  initial begin
    int len;
    forever begin
      len = pick_gap();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin
    rng_result_t exp_res;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result next_gen_word=%0d draw=%0d fraction=%0d",
                 $time, next_gen_word, draw, fraction);
        error_count++;
      end else begin
        exp_res = pending_draws.pop_front();
        if (next_gen_word !== exp_res.next_word) begin
          $display("%0t: next_gen_word expected %0d actual %0d",
                   $time, exp_res.next_word, next_gen_word);
          error_count++;
        end
        if (draw !== exp_res.draw) begin
          $display("%0t: draw expected %0d actual %0d", $time, exp_res.draw, draw);
          error_count++;
        end
        if (fraction !== exp_res.fraction) begin
          $display("%0t: fraction expected %0d actual %0d",
                   $time, exp_res.fraction, fraction);
          error_count++;
        end
      end
    end
  end

  // Drop the run after too long without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, pending_draws.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
